// ===== rtl/asset_price_convert_top_defines.svh =====
// Assertion macros for the price conversion block
`ifndef ASSET_PRICE_CONVERT_TOP_DEFINES_SVH
`define ASSET_PRICE_CONVERT_TOP_DEFINES_SVH
// assert that an implication holds at every edge out of reset
`define APC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// assert that a non-overlapping implication holds out of reset
`define APC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/apc_pkg.sv =====
// Package of types and constants for the price conversion block
`default_nettype none
package apc_pkg;
	localparam int AmtW = 63;
	localparam int SymW = 64;
	localparam int ProdW = 126;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_ZERODIV = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;
	localparam logic [1:0] REG_BASE_AMT = 2'd0;
	localparam logic [1:0] REG_QUOTE_AMT = 2'd1;
	localparam logic [1:0] REG_BASE_SYM = 2'd2;
	localparam logic [1:0] REG_QUOTE_SYM = 2'd3;

	typedef struct packed {
		logic [SymW-1:0] sym;
		logic [1:0]      status;
	} tag_t;

	function automatic logic [SymW-1:0] name_of(input logic [SymW-1:0] s);
		logic [SymW-1:0] k;
		logic            live;
		k = '0;
		live = 1'b1;
		for (int i = 1; i < 8; i++) begin
			if (s[8*i +: 8] == 8'd0) live = 1'b0;
			if (live) k[8*i +: 8] = s[8*i +: 8];
		end
		return k;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/apc_mul.sv =====
// Pipelined 63 by 63 multiplier from four partial products of 32-bit and 31-bit halves
`default_nettype none
module apc_mul (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [62:0]           a,
	input  wire logic [62:0]           b,
	output logic [apc_pkg::ProdW-1:0]  p
);
	import apc_pkg::*;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= 64'(a[31:0]) * 64'(b[62:32]);
			hl_s1 <= 64'(a[62:32]) * 64'(b[31:0]);
			hh_s1 <= 64'(a[62:32]) * 64'(b[62:32]);
			p <= ProdW'({64'd0, ll_s1} + ({64'd0, lh_s1} << 32) + ({64'd0, hl_s1} << 32)
				+ ({hh_s1, 64'd0}));
		end
	end
endmodule
`default_nettype wire

// ===== rtl/apc_div.sv =====
// Pipelined restoring divider: an overflow check stage, then one quotient bit per stage over 63 stages
`default_nettype none
module apc_div (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [apc_pkg::ProdW-1:0] n,
	input  wire logic [62:0]          d,
	input  wire apc_pkg::tag_t        tag_in,
	output logic [62:0]               q,
	output logic                      ovf,
	output apc_pkg::tag_t             tag_out
);
	import apc_pkg::*;
	localparam int Steps = 63;
	// quotient must stay below 2^63, so first check top bits against d
	logic [ProdW-1:0] n_s [Steps+1];
	logic [63:0]      r_s [Steps+1];
	logic [62:0]      d_s [Steps+1];
	logic [63:0]      q_s [Steps+1];
	logic             o_s [Steps+1];
	tag_t             t_s [Steps+1];
	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= n;
			r_s[0] <= 64'(n[ProdW-1:63]);
			d_s[0] <= d;
			q_s[0] <= '0;
			o_s[0] <= (n[ProdW-1:63] >= d);
			t_s[0] <= tag_in;
		end
	end
	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic [64:0] rr;
		assign rr = {r_s[g][63:0], n_s[g][62-g]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g+1] <= n_s[g];
				d_s[g+1] <= d_s[g];
				o_s[g+1] <= o_s[g];
				t_s[g+1] <= t_s[g];
				if (rr >= {2'd0, d_s[g]}) begin
					r_s[g+1] <= 64'(rr - {2'd0, d_s[g]});
					q_s[g+1] <= {q_s[g][62:0], 1'b1};
				end else begin
					r_s[g+1] <= rr[63:0];
					q_s[g+1] <= {q_s[g][62:0], 1'b0};
				end
			end
		end
	end
	assign q = q_s[Steps][62:0];
	assign ovf = o_s[Steps];
	assign tag_out = t_s[Steps];
	logic unused;
	assign unused = ^{q_s[Steps][63], r_s[Steps], n_s[Steps], d_s[Steps]};
endmodule
`default_nettype wire

// ===== rtl/asset_price_convert_top.sv =====
// Top level of the price conversion block
// Usage: input beats (asset_amount, asset_symbol) on in_valid/in_ready,
// results (converted_amount, result_symbol, status) on out_valid/out_ready.
// Registers are to be written through cfg_we/cfg_index/cfg_data while
// idle; the block itself does not enforce this. Throughput: one beat per
// cycle while no result waits on a low out_ready. Each beat passes
// through 67 register stages: the match stage, two multiplier stages,
// the divider's overflow check stage and its 63 restoring stages.
// The whole pipeline advances together; when out_ready is low and a
// result waits, every stage holds and in_ready falls, so no beat is lost.
// Reset clears all valid bits and loads the reset register values
// (amounts 1, symbols 0). No clearing pass is needed.
// A symbol that matches neither side gives status 1, a zero divisor
// status 2, and a quotient at or above 2^63 saturates with status 3.
`default_nettype none
`include "asset_price_convert_top_defines.svh"
module asset_price_convert_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [62:0] asset_amount,
	input  wire logic [63:0] asset_symbol,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [62:0]      converted_amount,
	output logic [63:0]      result_symbol,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import apc_pkg::*;
	localparam int Lat = 67;
	logic [62:0] base_amt_q, quote_amt_q;
	logic [63:0] base_sym_q, quote_sym_q;
	logic [Lat-1:0] vld_q;
	logic en;
	assign en = !vld_q[Lat-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_amt_q <= 63'd1; quote_amt_q <= 63'd1;
			base_sym_q <= '0; quote_sym_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_AMT:  base_amt_q <= cfg_data[62:0];
				REG_QUOTE_AMT: quote_amt_q <= cfg_data[62:0];
				REG_BASE_SYM:  base_sym_q <= cfg_data;
				REG_QUOTE_SYM: quote_sym_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Lat-2:0], in_valid};
	end

	logic [62:0] amt_s1, mult_s1, div_s1;
	tag_t tag_s1, tag_s2, tag_s3;
	logic [62:0] div_s2, div_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			amt_s1 <= asset_amount;
			if (name_of(asset_symbol) == name_of(base_sym_q)) begin
				mult_s1 <= quote_amt_q; div_s1 <= base_amt_q;
				tag_s1 <= '{sym: quote_sym_q,
					status: (base_amt_q == '0) ? ST_ZERODIV : ST_OK};
			end else if (name_of(asset_symbol) == name_of(quote_sym_q)) begin
				mult_s1 <= base_amt_q; div_s1 <= quote_amt_q;
				tag_s1 <= '{sym: base_sym_q,
					status: (quote_amt_q == '0) ? ST_ZERODIV : ST_OK};
			end else begin
				mult_s1 <= '0; div_s1 <= 63'd1;
				tag_s1 <= '{sym: '0, status: ST_NOMATCH};
			end
			tag_s2 <= tag_s1; div_s2 <= div_s1;
			tag_s3 <= tag_s2; div_s3 <= div_s2;
		end
	end

	logic [ProdW-1:0] prod;
	apc_mul u_mul (.clk(clk), .en(en), .a(amt_s1), .b(mult_s1), .p(prod));

	logic [62:0] q;
	logic ovf;
	tag_t tag_d;
	apc_div u_div (.clk(clk), .en(en), .n(prod), .d(div_s3), .tag_in(tag_s3),
		.q(q), .ovf(ovf), .tag_out(tag_d));

	always_comb begin
		converted_amount = '0;
		result_symbol = '0;
		status = tag_d.status;
		if (tag_d.status == ST_OK) begin
			result_symbol = tag_d.sym;
			if (ovf) begin
				converted_amount = '1;
				status = ST_OVF;
			end else converted_amount = q;
		end
	end

	`APC_ASSERT_IMPL(a_stall_hold, out_valid && !out_ready, !in_ready)
	`APC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
	`APC_ASSERT_IMPL(a_nomatch_zero, out_valid && status == ST_NOMATCH,
		converted_amount == '0 && result_symbol == '0)
endmodule
`default_nettype wire
